>>> hw/rtl/rtc_time_calendar_counter_core_macros.svh
// Assertion helpers shared by the RTC RTL. Both sample on clk and are
// disabled while rst is high.
`ifndef RTC_TIME_CALENDAR_COUNTER_CORE_MACROS_SVH
`define RTC_TIME_CALENDAR_COUNTER_CORE_MACROS_SVH

// Condition that must hold at every clock edge.
`define RTCCAL_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define RTCCAL_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rtccal_pkg.sv
package rtccal_pkg;

  // Field widths
  localparam int OPCODE_W    = 2;
  localparam int VALUE_W     = 27;
  localparam int HOUR_W      = 5;
  localparam int MIN_W       = 6;
  localparam int SEC_W       = 6;
  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int TICK_W      = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;

  // Command codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 2'd0,
    OP_SET_TIME = 2'd1,
    OP_SET_DATE = 2'd2
  } opcode_t;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HOUR_FORMAT_12 = 2'd0,
    CFG_MIN_YEAR       = 2'd1,
    CFG_MAX_YEAR       = 2'd2
  } cfg_index_t;

  // Time and date limits
  localparam logic [SEC_W-1:0]   SEC_TOP        = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_TOP        = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_TOP       = 5'd23;
  localparam logic [HOUR_W-1:0]  HOURS_PER_HALF = 5'd12;
  localparam logic [HOUR_W-1:0]  HOURS_PER_DAY  = 5'd24;
  localparam logic [DAY_W-1:0]   DAY_FIRST      = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LEAP_FEB   = 5'd29;
  localparam logic [MONTH_W-1:0] MONTH_FIRST    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_TOP      = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_TOP       = 14'd9999;

  // Reset values
  localparam logic [HOUR_W-1:0]  RST_HOUR     = 5'd0;
  localparam logic [MIN_W-1:0]   RST_MINUTE   = 6'd0;
  localparam logic [SEC_W-1:0]   RST_SECOND   = 6'd0;
  localparam logic [DAY_W-1:0]   RST_DAY      = 5'd28;
  localparam logic [MONTH_W-1:0] RST_MONTH    = 4'd2;
  localparam logic [YEAR_W-1:0]  RST_YEAR     = 14'd2020;
  localparam logic [YEAR_W-1:0]  RST_MIN_YEAR = 14'd1970;
  localparam logic [YEAR_W-1:0]  RST_MAX_YEAR = 14'd2100;

  // Set-command range checks
  localparam logic [VALUE_W-1:0] TIME_VALUE_LIMIT = 27'd10000;
  localparam logic [VALUE_W-1:0] DATE_VALUE_LIMIT = 27'd100000000;

  // Decimal field extraction: reciprocal multipliers, exact over the used range
  localparam int                  TIME_VALUE_W      = 14;
  localparam int                  HOUR_Q_W          = 8;
  localparam logic [13:0]         HOUR_RECIP        = 14'd10486;
  localparam int                  HOUR_RECIP_SHIFT  = 20;
  localparam logic [6:0]          HOUR_SCALE        = 7'd100;
  localparam logic [26:0]         YEAR_RECIP        = 27'd109951163;
  localparam int                  YEAR_RECIP_SHIFT  = 40;
  localparam logic [13:0]         YEAR_SCALE        = 14'd10000;
  localparam int                  REM_W             = 28;
  localparam int                  REM_SMALL_W       = 11;
  localparam logic [10:0]         MONTH_RECIP       = 11'd1311;
  localparam int                  MONTH_RECIP_SHIFT = 17;
  localparam logic [6:0]          MONTH_SCALE       = 7'd100;
  localparam logic signed [27:0]  REM_MONTH_LO      = 28'sd100;
  localparam logic signed [27:0]  REM_MONTH_HI      = 28'sd1300;
  localparam logic signed [27:0]  REM_DAY_LO        = 28'sd1;

  // Divisibility by 25 via the modular inverse of 25 mod 2^16
  localparam logic [15:0] INV25       = 16'd23593;
  localparam logic [15:0] DIV25_LIMIT = 16'd2621;

  localparam int MONTH_IDX_W = 4;
  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Configuration register file
  typedef struct packed {
    logic              hour_format_12;
    logic [YEAR_W-1:0] min_year;
    logic [YEAR_W-1:0] max_year;
  } cfg_t;

  // Decoded item handed to the state stage
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                set_error;
    logic [HOUR_W-1:0]   hours;
    logic [MIN_W-1:0]    minutes;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
  } dec_t;

  // Gregorian leap year: div by 4, and not by 100 unless by 400.
  // Div by 100 == div by 4 and 25; div by 400 == div by 16 and 25.
  function automatic logic is_leap(input logic [YEAR_W-1:0] year);
    logic [15:0] mod_probe;
    mod_probe = 16'({2'b00, year} * INV25);
    return (year[1:0] == 2'b00) &&
           ((mod_probe > DIV25_LIMIT) || (year[3:0] == 4'b0000));
  endfunction

  // Month length; a month code outside 1..12 reads as January
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic               leap);
    logic [MONTH_IDX_W-1:0] idx;
    logic [DAY_W-1:0]       len;
    idx = (month >= MONTH_FIRST && month <= MONTH_TOP) ?
          MONTH_IDX_W'(month - MONTH_FIRST) : '0;
    len = MONTH_LEN[idx];
    if (idx == MONTH_IDX_W'(1) && leap) len = DAY_LEAP_FEB;
    return len;
  endfunction

endpackage

>>> hw/rtl/rtccal_cmd_if.sv
// Command channel: one item per valid/ready handshake
interface rtccal_cmd_if
  import rtccal_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

>>> hw/rtl/rtccal_rsp_if.sv
// Result channel: current time and date after each item
interface rtccal_rsp_if
  import rtccal_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [HOUR_W-1:0]  hours;
  logic [MIN_W-1:0]   minutes;
  logic [SEC_W-1:0]   seconds;
  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic [TICK_W-1:0]  tick_total;
  logic               time_updated;
  logic               set_error;

  modport source (
    output valid, output hours, output minutes, output seconds, output day,
    output month, output year, output tick_total, output time_updated,
    output set_error, input ready
  );
  modport sink (
    input valid, input hours, input minutes, input seconds, input day,
    input month, input year, input tick_total, input time_updated,
    input set_error, output ready
  );
endinterface

>>> hw/rtl/rtccal_set_decode.sv
// Five-stage pipeline that turns a set-time / set-date value into clamped
// time and date fields. Nothing here depends on the clock state, so items
// stream through one per cycle; stalls collapse bubbles stage by stage.
module rtccal_set_decode
  import rtccal_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rtccal_cmd_if.sink   cmd,
  input  cfg_t         cfg,
  output logic         dec_valid,
  input  logic         dec_ready,
  output dec_t         dec
);

  // Stage registers
  logic                      s0_valid;
  logic [OPCODE_W-1:0]       s0_op;
  logic [VALUE_W-1:0]        s0_value;

  logic                      s1_valid;
  logic [OPCODE_W-1:0]       s1_op;
  logic [VALUE_W-1:0]        s1_value;
  logic                      s1_err;
  logic [YEAR_W-1:0]         s1_year_q;
  logic [HOUR_Q_W-1:0]       s1_hour_q;

  logic                      s2_valid;
  logic [OPCODE_W-1:0]       s2_op;
  logic                      s2_err;
  logic [YEAR_W-1:0]         s2_year;
  logic signed [REM_W-1:0]   s2_rem;
  logic [HOUR_W-1:0]         s2_hour;
  logic [MIN_W-1:0]          s2_minute;

  logic                      s3_valid;
  logic [OPCODE_W-1:0]       s3_op;
  logic                      s3_err;
  logic [YEAR_W-1:0]         s3_year;
  logic [MONTH_W-1:0]        s3_month;
  logic signed [REM_W-1:0]   s3_rem;
  logic                      s3_leap;
  logic [HOUR_W-1:0]         s3_hour;
  logic [MIN_W-1:0]          s3_minute;

  logic                      s4_valid;
  dec_t                      s4;

  // Stage load enables, from the output back
  logic en0, en1, en2, en3, en4;

  assign en4 = !s4_valid || dec_ready;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign en0 = !s0_valid || en1;

  assign cmd.ready = en0;
  assign dec_valid = s4_valid;
  assign dec       = s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (en0) s0_valid <= cmd.valid;
      if (en1) s1_valid <= s0_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      if (en4) s4_valid <= s3_valid;
    end
  end

  // Stage 1: value range check, raw hour = v/100 and raw year = v/10000
  logic [2*VALUE_W-1:0]       year_prod;
  logic [2*TIME_VALUE_W-1:0]  hour_prod;
  logic                       err1;

  assign year_prod = (2*VALUE_W)'(s0_value) * (2*VALUE_W)'(YEAR_RECIP);
  assign hour_prod = (2*TIME_VALUE_W)'(s0_value[TIME_VALUE_W-1:0]) *
                     (2*TIME_VALUE_W)'(HOUR_RECIP);
  assign err1 = ((s0_op == OP_SET_TIME) && (s0_value >= TIME_VALUE_LIMIT)) ||
                ((s0_op == OP_SET_DATE) && (s0_value >= DATE_VALUE_LIMIT));

  // Stage 2: clamp year and hour, leftover month/day digits and minute
  logic [YEAR_W-1:0]         year_hi, year_lo, year_c;
  logic [REM_W-1:0]          year_scaled;
  logic signed [REM_W-1:0]   rem2;
  logic [HOUR_W-1:0]         hour_c, hour_disp;
  logic [TIME_VALUE_W-1:0]   hour_scaled, min_rem;
  logic [MIN_W-1:0]          min_c;

  always_comb begin
    year_hi = (cfg.max_year > YEAR_TOP) ? YEAR_TOP : cfg.max_year;
    year_lo = (cfg.min_year > YEAR_TOP) ? YEAR_TOP : cfg.min_year;
    if (s1_year_q > year_hi)      year_c = year_hi;
    else if (s1_year_q < year_lo) year_c = year_lo;
    else                          year_c = s1_year_q;
    year_scaled = REM_W'(year_c) * REM_W'(YEAR_SCALE);
    rem2 = $signed({1'b0, s1_value}) - $signed(year_scaled);

    hour_c = (s1_hour_q > HOUR_Q_W'(HOUR_TOP)) ? HOUR_TOP : s1_hour_q[HOUR_W-1:0];
    hour_scaled = TIME_VALUE_W'(hour_c) * TIME_VALUE_W'(HOUR_SCALE);
    min_rem = s1_value[TIME_VALUE_W-1:0] - hour_scaled;
    min_c = (min_rem > TIME_VALUE_W'(MIN_TOP)) ? MIN_TOP : min_rem[MIN_W-1:0];

    // 12-hour display: midnight hour shows as 12, afternoon loses 12
    hour_disp = hour_c;
    if (cfg.hour_format_12) begin
      if (hour_c == '0)                 hour_disp = HOURS_PER_HALF;
      else if (hour_c > HOURS_PER_HALF) hour_disp = hour_c - HOURS_PER_HALF;
    end
  end

  // Stage 3: month = rem/100 truncated, clamped to 1..12; leap flag
  logic [2*REM_SMALL_W-1:0]  month_prod;
  logic [MONTH_W-1:0]        month_c;

  always_comb begin
    month_prod = (2*REM_SMALL_W)'(s2_rem[REM_SMALL_W-1:0]) *
                 (2*REM_SMALL_W)'(MONTH_RECIP);
    if (s2_rem < REM_MONTH_LO)       month_c = MONTH_FIRST;
    else if (s2_rem >= REM_MONTH_HI) month_c = MONTH_TOP;
    else                             month_c = month_prod[MONTH_RECIP_SHIFT +: MONTH_W];
  end

  // Stage 4: day = rem - month*100, clamped to 1..month length
  logic signed [REM_W-1:0]   day_full;
  logic [DAY_W-1:0]          day_len, day_c;

  always_comb begin
    day_full = s3_rem - $signed(REM_W'(s3_month) * REM_W'(MONTH_SCALE));
    day_len  = days_in(s3_month, s3_leap);
    if (day_full > $signed(REM_W'(day_len))) day_c = day_len;
    else if (day_full < REM_DAY_LO)          day_c = DAY_FIRST;
    else                                     day_c = day_full[DAY_W-1:0];
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en0) begin
      s0_op    <= cmd.opcode;
      s0_value <= cmd.value;
    end
    if (en1) begin
      s1_op     <= s0_op;
      s1_value  <= s0_value;
      s1_err    <= err1;
      s1_year_q <= year_prod[YEAR_RECIP_SHIFT +: YEAR_W];
      s1_hour_q <= hour_prod[HOUR_RECIP_SHIFT +: HOUR_Q_W];
    end
    if (en2) begin
      s2_op     <= s1_op;
      s2_err    <= s1_err;
      s2_year   <= year_c;
      s2_rem    <= rem2;
      s2_hour   <= hour_disp;
      s2_minute <= min_c;
    end
    if (en3) begin
      s3_op     <= s2_op;
      s3_err    <= s2_err;
      s3_year   <= s2_year;
      s3_month  <= month_c;
      s3_rem    <= s2_rem;
      s3_leap   <= is_leap(s2_year);
      s3_hour   <= s2_hour;
      s3_minute <= s2_minute;
    end
    if (en4) begin
      s4.opcode    <= s3_op;
      s4.set_error <= s3_err;
      s4.hours     <= s3_hour;
      s4.minutes   <= s3_minute;
      s4.year      <= s3_year;
      s4.month     <= s3_month;
      s4.day       <= day_c;
    end
  end

endmodule

>>> hw/rtl/rtc_time_calendar_counter_core.sv
// Real-time clock and calendar. Each tick item adds one second (hours wrap
// at 24, or at 12 with hour_format_12 set) and rolls the Gregorian date at
// 00:00:00; set-time loads a decimal hhmm and set-date a decimal yyyymmdd,
// clamped per field (year to min_year..max_year), or reports set_error and
// leaves the state alone when the value has too many digits. Every item
// returns exactly one result holding the time, date and 32-bit tick count
// after that item. The block takes one item per clock while rsp is not
// stalled: the decimal fields go through a five-stage decode pipeline
// (s0 to s4), then update the clock/calendar state, which is also the
// result register. While a result waits, up to five more items are held in
// the pipeline. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while idle, which the block does not enforce.
`include "rtc_time_calendar_counter_core_macros.svh"

module rtc_time_calendar_counter_core
  import rtccal_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rtccal_cmd_if.sink             cmd,
  rtccal_rsp_if.source           rsp
);

  // Configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hour_format_12 <= 1'b0;
      cfg.min_year       <= RST_MIN_YEAR;
      cfg.max_year       <= RST_MAX_YEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOUR_FORMAT_12: cfg.hour_format_12 <= cfg_data[0];
        CFG_MIN_YEAR:       cfg.min_year       <= cfg_data;
        CFG_MAX_YEAR:       cfg.max_year       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Set-command decode pipeline
  logic dec_valid;
  logic take;
  dec_t dec;

  rtccal_set_decode u_set_decode (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .dec_valid (dec_valid),
    .dec_ready (take),
    .dec       (dec)
  );

  // Clock/calendar state doubles as the result register
  logic               rsp_valid;
  logic [HOUR_W-1:0]  hour_reg, hour_reg_next;
  logic [MIN_W-1:0]   minute_reg, minute_reg_next;
  logic [SEC_W-1:0]   second_reg, second_reg_next;
  logic [DAY_W-1:0]   day_reg, day_reg_next;
  logic [MONTH_W-1:0] month_reg, month_reg_next;
  logic [YEAR_W-1:0]  year_reg, year_reg_next;
  logic [TICK_W-1:0]  tick_count, tick_count_next;
  logic               time_updated, time_updated_next;
  logic               set_error, set_error_next;
  logic               commit;

  assign take   = !rsp_valid || rsp.ready;
  assign commit = dec_valid && take;

  // One-second advance
  logic              sec_wrap, min_wrap, midnight;
  logic [HOUR_W-1:0] hour_inc, hour_wrapped, tick_hour;
  logic [MIN_W-1:0]  tick_min;
  logic [SEC_W-1:0]  tick_sec;

  always_comb begin
    sec_wrap = second_reg >= SEC_TOP;
    min_wrap = minute_reg >= MIN_TOP;
    hour_inc = hour_reg + 5'd1;
    if (hour_inc >= HOURS_PER_DAY)
      hour_wrapped = hour_inc - HOURS_PER_DAY;
    else if (cfg.hour_format_12 && hour_inc >= HOURS_PER_HALF)
      hour_wrapped = hour_inc - HOURS_PER_HALF;
    else
      hour_wrapped = hour_inc;
    tick_sec  = sec_wrap ? '0 : second_reg + 6'd1;
    tick_min  = sec_wrap ? (min_wrap ? '0 : minute_reg + 6'd1) : minute_reg;
    tick_hour = (sec_wrap && min_wrap) ? hour_wrapped : hour_reg;
    midnight  = (tick_sec == '0) && (tick_min == '0) && (tick_hour == '0);
  end

  // One-day advance
  logic [DAY_W-1:0]   cur_len, adv_day;
  logic [MONTH_W-1:0] adv_month;
  logic [YEAR_W-1:0]  adv_year;

  always_comb begin
    cur_len   = days_in(month_reg, is_leap(year_reg));
    adv_day   = day_reg + 5'd1;
    adv_month = month_reg;
    adv_year  = year_reg;
    if (day_reg >= cur_len) begin
      adv_day = DAY_FIRST;
      if (month_reg >= MONTH_TOP) begin
        adv_month = MONTH_FIRST;
        adv_year  = (year_reg >= YEAR_TOP) ? '0 : year_reg + 14'd1;
      end else begin
        adv_month = month_reg + 4'd1;
      end
    end
  end

  // Next state per command
  always_comb begin
    hour_reg_next     = hour_reg;
    minute_reg_next   = minute_reg;
    second_reg_next   = second_reg;
    day_reg_next      = day_reg;
    month_reg_next    = month_reg;
    year_reg_next     = year_reg;
    tick_count_next   = tick_count;
    time_updated_next = 1'b0;
    set_error_next    = 1'b0;
    unique case (dec.opcode)
      OP_TICK: begin
        tick_count_next   = tick_count + 32'd1;
        hour_reg_next     = tick_hour;
        minute_reg_next   = tick_min;
        second_reg_next   = tick_sec;
        time_updated_next = 1'b1;
        if (midnight) begin
          day_reg_next   = adv_day;
          month_reg_next = adv_month;
          year_reg_next  = adv_year;
        end
      end
      OP_SET_TIME: begin
        set_error_next = dec.set_error;
        if (!dec.set_error) begin
          hour_reg_next   = dec.hours;
          minute_reg_next = dec.minutes;
          second_reg_next = '0;
        end
      end
      OP_SET_DATE: begin
        set_error_next = dec.set_error;
        if (!dec.set_error) begin
          day_reg_next   = dec.day;
          month_reg_next = dec.month;
          year_reg_next  = dec.year;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid    <= 1'b0;
      hour_reg     <= RST_HOUR;
      minute_reg   <= RST_MINUTE;
      second_reg   <= RST_SECOND;
      day_reg      <= RST_DAY;
      month_reg    <= RST_MONTH;
      year_reg     <= RST_YEAR;
      tick_count   <= '0;
      time_updated <= 1'b0;
      set_error    <= 1'b0;
    end else begin
      if (take) rsp_valid <= dec_valid;
      if (commit) begin
        hour_reg     <= hour_reg_next;
        minute_reg   <= minute_reg_next;
        second_reg   <= second_reg_next;
        day_reg      <= day_reg_next;
        month_reg    <= month_reg_next;
        year_reg     <= year_reg_next;
        tick_count   <= tick_count_next;
        time_updated <= time_updated_next;
        set_error    <= set_error_next;
      end
    end
  end

  // Result channel
  assign rsp.valid        = rsp_valid;
  assign rsp.hours        = hour_reg;
  assign rsp.minutes      = minute_reg;
  assign rsp.seconds      = second_reg;
  assign rsp.day          = day_reg;
  assign rsp.month        = month_reg;
  assign rsp.year         = year_reg;
  assign rsp.tick_total   = tick_count;
  assign rsp.time_updated = time_updated;
  assign rsp.set_error    = set_error;

  // Checks
  `RTCCAL_CHECK(a_time_range, (hour_reg <= HOUR_TOP) && (minute_reg <= MIN_TOP) && (second_reg <= SEC_TOP), "time field out of range")
  `RTCCAL_CHECK(a_date_range, (month_reg >= MONTH_FIRST) && (month_reg <= MONTH_TOP) && (day_reg >= DAY_FIRST) && (day_reg <= days_in(month_reg, is_leap(year_reg))) && (year_reg <= YEAR_TOP), "date out of range")
  `RTCCAL_CHECK_NEXT(a_reject_holds, commit && dec.set_error, $stable(hour_reg) && $stable(minute_reg) && $stable(day_reg) && $stable(month_reg) && $stable(year_reg), "rejected set changed state")
  `RTCCAL_CHECK_NEXT(a_tick_count, commit && (dec.opcode == OP_TICK), tick_count == 32'($past(tick_count) + 32'd1), "tick count did not advance")
  `RTCCAL_CHECK_NEXT(a_day_at_midnight, commit && (dec.opcode == OP_TICK), (day_reg != $past(day_reg)) == ((hour_reg == '0) && (minute_reg == '0) && (second_reg == '0)), "date advance not tied to midnight")

endmodule

>>> sim/rtc_time_calendar_counter_core_checker.sv
// Watches the command, result and register ports, keeps its own copy of
// the clock/calendar state and checks every result against it in order.
module rtc_time_calendar_counter_core_checker
  import rtccal_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rtccal_cmd_if                  cmd,
  rtccal_rsp_if                  rsp,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [HOUR_W-1:0]  hours;
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   seconds;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [TICK_W-1:0]  tick_total;
    logic               time_updated;
    logic               set_error;
  } rtc_reading_t;

  rtc_reading_t pending_readings[$];

  // Shadow configuration
  bit fmt12;
  int min_yr;
  int max_yr;

  // Shadow clock/calendar state
  int                hour_q;
  int                minute_q;
  int                second_q;
  int                day_q;
  int                month_q;
  int                year_q;
  logic [TICK_W-1:0] tick_q;

  function automatic bit leap_year(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Out-of-range month codes read as January
  function automatic int month_days(input int m, input int y);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic void bump_day();
    if (day_q >= month_days(month_q, year_q)) begin
      day_q = 1;
      if (month_q >= 12) begin
        month_q = 1;
        year_q  = (year_q >= 9999) ? 0 : year_q + 1;
      end else begin
        month_q++;
      end
    end else begin
      day_q++;
    end
  endfunction

  // Hour wraps modulo the format in force at the moment of the wrap
  function automatic void bump_second();
    int base;
    base = fmt12 ? 12 : 24;
    if (second_q >= 59) begin
      second_q = 0;
      if (minute_q >= 59) begin
        minute_q = 0;
        hour_q   = (hour_q + 1) % base;
      end else begin
        minute_q++;
      end
    end else begin
      second_q++;
    end
  endfunction

  function automatic bit load_time(input int v);
    int h;
    int m;
    if (v >= 10000) return 1'b0;
    h = v / 100;
    if (h > 23) h = 23;
    // minute uses the clamped hour, before any 12-hour fixup
    m = v - h * 100;
    if (m > 59) m = 59;
    hour_q = h;
    if (fmt12) begin
      if (h == 0) hour_q = 12;
      else if (h > 12) hour_q = h - 12;
    end
    minute_q = m;
    second_q = 0;
    return 1'b1;
  endfunction

  function automatic bit load_date(input int v);
    longint y;
    longint m;
    longint d;
    longint lo;
    longint hi;
    longint len;
    if (v >= 100000000) return 1'b0;
    hi = (max_yr > 9999) ? 9999 : max_yr;
    lo = (min_yr > 9999) ? 9999 : min_yr;
    y = v / 10000;
    if (y > hi) y = hi;
    else if (y < lo) y = lo;
    // remainders may go negative once the year is clamped upward
    m = (longint'(v) - y * 10000) / 100;
    if (m > 12) m = 12;
    else if (m < 1) m = 1;
    len = month_days(int'(m), int'(y));
    d = longint'(v) - y * 10000 - m * 100;
    if (d > len) d = len;
    else if (d < 1) d = 1;
    year_q  = int'(y);
    month_q = int'(m);
    day_q   = int'(d);
    return 1'b1;
  endfunction

  function automatic rtc_reading_t step_clock(input logic [OPCODE_W-1:0] op,
                                              input int v);
    rtc_reading_t r;
    r.time_updated = 1'b0;
    r.set_error    = 1'b0;
    case (op)
      OP_TICK: begin
        tick_q = tick_q + 1'b1;
        bump_second();
        if (hour_q == 0 && minute_q == 0 && second_q == 0) bump_day();
        r.time_updated = 1'b1;
      end
      OP_SET_TIME: r.set_error = !load_time(v);
      OP_SET_DATE: r.set_error = !load_date(v);
      default: ;
    endcase
    r.hours      = HOUR_W'(hour_q);
    r.minutes    = MIN_W'(minute_q);
    r.seconds    = SEC_W'(second_q);
    r.day        = DAY_W'(day_q);
    r.month      = MONTH_W'(month_q);
    r.year       = YEAR_W'(year_q);
    r.tick_total = tick_q;
    return r;
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    rtc_reading_t want;
    if (rst) begin
      fmt12    = 1'b0;
      min_yr   = 1970;
      max_yr   = 2100;
      hour_q   = 0;
      minute_q = 0;
      second_q = 0;
      day_q    = 28;
      month_q  = 2;
      year_q   = 2020;
      tick_q   = '0;
      pending_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOUR_FORMAT_12: fmt12  = cfg_data[0];
          CFG_MIN_YEAR:       min_yr = int'(cfg_data);
          CFG_MAX_YEAR:       max_yr = int'(cfg_data);
          default: ;
        endcase
      end

      // compare before queuing this edge's item, so a stray result never
      // matches an item accepted on the same edge
      if (rsp.valid && rsp.ready) begin
        if (pending_readings.size() == 0) begin
          if (mismatches < 10) $display("%0t: result with no item pending", $time);
          mismatches++;
        end else begin
          want = pending_readings.pop_front();
          if (rsp.hours !== want.hours || rsp.minutes !== want.minutes ||
              rsp.seconds !== want.seconds || rsp.day !== want.day ||
              rsp.month !== want.month || rsp.year !== want.year ||
              rsp.tick_total !== want.tick_total ||
              rsp.time_updated !== want.time_updated ||
              rsp.set_error !== want.set_error) begin
            if (mismatches < 10) begin
              $display("%0t: expected %0d:%0d:%0d %0d-%0d-%0d ticks %0d upd %0b err %0b",
                       $time, want.hours, want.minutes, want.seconds, want.year,
                       want.month, want.day, want.tick_total, want.time_updated,
                       want.set_error);
              $display("%0t: actual   %0d:%0d:%0d %0d-%0d-%0d ticks %0d upd %0b err %0b",
                       $time, rsp.hours, rsp.minutes, rsp.seconds, rsp.year,
                       rsp.month, rsp.day, rsp.tick_total, rsp.time_updated,
                       rsp.set_error);
            end
            mismatches++;
          end
        end
      end

      if (cmd.valid && cmd.ready)
        pending_readings.push_back(step_clock(cmd.opcode, int'(cmd.value)));
    end
    outstanding <= pending_readings.size();
  end

endmodule

>>> sim/rtc_time_calendar_counter_core_tb.sv
module rtc_time_calendar_counter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtccal_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 290;
  localparam int NUM_PHASES      = 5;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int outstanding;
  int idle_pct;
  int stall_pct = 0;

  rtccal_cmd_if cmd ();
  rtccal_rsp_if rsp ();

  rtc_time_calendar_counter_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  rtc_time_calendar_counter_core_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side backpressure
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("rtc_time_calendar_counter_core_tb failed");
    $finish;
  end

  // One item; valid stays high into the next call unless a gap is drawn
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      cmd.valid = 1'b0;
      @(negedge clk);
    end
    cmd.valid  = 1'b1;
    cmd.opcode = op;
    cmd.value  = v;
    do @(posedge clk); while (!cmd.ready);
  endtask

  // Stop sending and let every result come back
  task automatic drain();
    @(negedge clk);
    cmd.valid = 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // yyyymmdd; month_end asks for a date that is the last day after clamping,
  // or day 28, which in February probes leap years
  function automatic logic [VALUE_W-1:0] pick_date(input bit month_end);
    int y;
    int m;
    int d;
    case ($urandom_range(7))
      0:       y = 2000;
      1:       y = 1900;
      2:       y = 2100;
      3:       y = 9999;
      4:       y = 0;
      5:       y = 2400;
      6:       y = $urandom_range(1969, 2101);
      default: y = $urandom_range(9999);
    endcase
    if ($urandom_range(2) == 0) m = $urandom_range(1) ? 12 : 2;
    else m = $urandom_range(1, 12);
    if (month_end) begin
      d = ($urandom_range(3) == 0) ? 28 : 31;
    end else begin
      d = $urandom_range(1, 31);
      if ($urandom_range(9) == 0) m = $urandom_range(99);
      if ($urandom_range(9) == 0) d = $urandom_range(99);
    end
    return VALUE_W'(y * 10000 + m * 100 + d);
  endfunction

  // Date set near month end, time set to the last minute of an hour, then
  // ticks that cross the hour in most runs and midnight in some
  task automatic run_rollover(inout int count);
    int hh;
    int n;
    case ($urandom_range(3))
      0:       hh = 23;
      1:       hh = 11;
      2:       hh = 12;
      default: hh = $urandom_range(23);
    endcase
    send_item(OP_SET_DATE, pick_date(1'b1));
    send_item(OP_SET_TIME, VALUE_W'(hh * 100 + 59));
    n = $urandom_range(58, 63);
    repeat (n) send_item(OP_TICK, VALUE_W'($urandom));
    count += n + 2;
  endtask

  task automatic run_random(inout int count);
    int r;
    int s;
    r = $urandom_range(99);
    if (r < 30) begin
      run_rollover(count);
    end else if (r < 55) begin
      send_item(OP_TICK, VALUE_W'($urandom));
      count++;
    end else if (r < 72) begin
      s = $urandom_range(9);
      if (s < 8) send_item(OP_SET_TIME, VALUE_W'($urandom_range(9999)));
      else if (s == 8) send_item(OP_SET_TIME, VALUE_W'($urandom_range(10000, 20000)));
      else send_item(OP_SET_TIME, VALUE_W'($urandom));
      count++;
    end else if (r < 94) begin
      s = $urandom_range(9);
      if (s < 7) send_item(OP_SET_DATE, pick_date(1'b0));
      else if (s == 7) send_item(OP_SET_DATE, VALUE_W'($urandom_range(99999999)));
      else if (s == 8)
        send_item(OP_SET_DATE, VALUE_W'($urandom_range(100000000, 134217727)));
      else send_item(OP_SET_DATE, VALUE_W'($urandom));
      count++;
    end else begin
      // leaves the block's state unchanged but still returns a result; not counted
      send_item(OP_UNUSED, VALUE_W'($urandom));
    end
  endtask

  initial begin
    int count;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = CFG_HOUR_FORMAT_12;
    cfg_data   = '0;
    cmd.valid  = 1'b0;
    cmd.opcode = OP_TICK;
    cmd.value  = '0;
    idle_pct   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes and clamps under the reset configuration
    send_item(OP_TICK, '0);
    send_item(OP_SET_TIME, '0);
    send_item(OP_SET_TIME, VALUE_W'(9999));
    send_item(OP_SET_TIME, VALUE_W'(10000));
    send_item(OP_SET_TIME, '1);
    send_item(OP_SET_TIME, VALUE_W'(1260));
    send_item(OP_SET_TIME, VALUE_W'(1200));
    send_item(OP_SET_DATE, '0);
    send_item(OP_SET_DATE, VALUE_W'(99999999));
    send_item(OP_SET_DATE, VALUE_W'(100000000));
    send_item(OP_SET_DATE, '1);
    send_item(OP_SET_DATE, VALUE_W'(20240229));
    send_item(OP_SET_DATE, VALUE_W'(21000229));
    send_item(OP_SET_DATE, VALUE_W'(20000229));
    send_item(OP_SET_DATE, VALUE_W'(20231301));
    send_item(OP_SET_DATE, VALUE_W'(20230015));
    send_item(OP_SET_DATE, VALUE_W'(20230431));
    send_item(OP_UNUSED, '1);
    send_item(OP_UNUSED, '0);
    send_item(OP_TICK, '1);
    send_item(OP_SET_TIME, VALUE_W'(2359));
    send_item(OP_TICK, '0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        1: begin
          write_reg(CFG_HOUR_FORMAT_12, CFG_DATA_W'({13'($urandom), 1'b1}));
          write_reg(CFG_MIN_YEAR, '0);
          write_reg(CFG_MAX_YEAR, CFG_DATA_W'(9999));
          idle_pct  = 46;
          stall_pct = 0;
        end
        2: begin
          // year limits above 9999 act as 9999
          write_reg(CFG_HOUR_FORMAT_12, CFG_DATA_W'({13'($urandom), 1'b0}));
          write_reg(CFG_MIN_YEAR, '1);
          write_reg(CFG_MAX_YEAR, '1);
          idle_pct  = 0;
          stall_pct = 46;
        end
        3: begin
          // lower limit above upper limit
          write_reg(CFG_HOUR_FORMAT_12, '1);
          write_reg(CFG_MIN_YEAR, CFG_DATA_W'(2500));
          write_reg(CFG_MAX_YEAR, CFG_DATA_W'(1500));
          idle_pct  = 36;
          stall_pct = 36;
        end
        4: begin
          write_reg(CFG_HOUR_FORMAT_12, '0);
          write_reg(CFG_MIN_YEAR, '0);
          write_reg(CFG_MAX_YEAR, '1);
          idle_pct  = 0;
          stall_pct = 0;
        end
        default: ;
      endcase

      // first ticks carry an hour set under the previous format across a wrap
      repeat (61) send_item(OP_TICK, VALUE_W'($urandom));
      count = 61;
      while (count < ITEMS_PER_PHASE) run_random(count);
      send_item(OP_SET_TIME, VALUE_W'(2259));
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("rtc_time_calendar_counter_core_tb passed");
    end else begin
      $display("rtc_time_calendar_counter_core_tb failed");
    end
    $finish;
  end

endmodule
